/* rtl/cnb_pkg.sv */
// Package: shared constants, types and state codes for the naive Bayes classifier.
`timescale 1ns / 1ps
package cnb_pkg;
	localparam int NUM_FEATURES_D = 14;
	localparam int ENTRIES_PER_COLUMN_D = 256;
	localparam int COUNT_BITS_D = 16;
	localparam int VALUE_BITS = 21;
	localparam int SUM_BITS = 24;
	localparam int LOG_BITS = 16;
	localparam int CORRECT_BITS = 16;
	localparam logic [0:0] FUNC_TRAIN = 1'b0;
	localparam logic [1:0] LABEL_LOW = 2'd1;
	localparam logic [1:0] LABEL_HIGH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_APPEND,
		ST_UPD,
		ST_LOGNORM,
		ST_LOGSQ,
		ST_ACC,
		ST_ROW
	} state_t;
endpackage

/* rtl/cnb_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cnb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/categorical_naive_bayes_top.sv */
// Top level: sequenced two-class categorical naive Bayes classifier.
//
// channel  | handshake           | fields
// ---------+---------------------+------------------------------------------------
// item in  | start && !busy      | func feature_index feature_value class_label
//          |                     | last_of_row
// result   | done (one cycle)    | predicted_class label_matches correct_total
//          |                     | table_overflow
//
// An item scans its column's table entries, each in a RAM read state and a compare
// state, then takes an append or update state where one applies and a row state; a
// classify hit adds four log2 evaluations (two counts, two totals) through one shared
// squaring multiplier and an accumulate state.
// Reset clears fill counts, totals, sums and flags; the tables need no clearing.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps
module categorical_naive_bayes_top
	import cnb_pkg::*;
#(
	parameter int NUM_FEATURES = NUM_FEATURES_D,
	parameter int ENTRIES_PER_COLUMN = ENTRIES_PER_COLUMN_D,
	parameter int COUNT_BITS = COUNT_BITS_D
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic [3:0]              feature_index,
	input  logic [VALUE_BITS-1:0]   feature_value,
	input  logic [1:0]              class_label,
	input  logic                    last_of_row,
	output logic                    done,
	output logic [1:0]              predicted_class,
	output logic                    label_matches,
	output logic [CORRECT_BITS-1:0] correct_total,
	output logic                    table_overflow
);
	localparam int COL_BITS = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int ENT_BITS = $clog2(ENTRIES_PER_COLUMN);
	localparam int FILL_BITS = $clog2(ENTRIES_PER_COLUMN + 1);
	localparam int DEPTH = NUM_FEATURES * ENTRIES_PER_COLUMN;
	localparam int ADDR_BITS = $clog2(DEPTH);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [FILL_BITS-1:0] FULL = FILL_BITS'(ENTRIES_PER_COLUMN);

	state_t state_q, state_d;

	logic                    func_q, last_q;
	logic [COL_BITS-1:0]     col_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [1:0]              label_q;
	logic [FILL_BITS-1:0]    fill_q [NUM_FEATURES];
	logic [FILL_BITS-1:0]    k_q;
	logic [COUNT_BITS-1:0]   tot_q [2];
	logic signed [SUM_BITS-1:0] sum_q [2];
	logic [1:0]              zflag_q;
	logic                    ovf_q;
	logic [CORRECT_BITS-1:0] correct_q;
	logic [COUNT_BITS-1:0]   lowc_q, highc_q;
	logic [ADDR_BITS-1:0]    at_q;
	// log unit
	logic [1:0]              lsel_q;     // 0 low count,1 low tot,2 high count,3 high tot
	logic [COUNT_BITS-1:0]   lx_q;
	logic [4:0]              le_q;
	logic [31:0]             lm_q;
	logic [3:0]              li_q;
	logic [8:0]              lf_q;
	logic [LOG_BITS-1:0]     lres_q [4];

	logic                    in_range;
	logic [ADDR_BITS-1:0]    base, ram_addr;
	logic                    ram_we;
	logic [VALUE_BITS-1:0]   v_rd, v_wd;
	logic [COUNT_BITS-1:0]   lo_rd, hi_rd, lo_wd, hi_wd;
	logic                    found;
	logic [FILL_BITS-1:0]    fill_c;

	assign in_range = {28'd0, feature_index} < 32'(NUM_FEATURES);
	assign fill_c = fill_q[col_q];
	assign base = ADDR_BITS'(32'(col_q) * ENTRIES_PER_COLUMN);
	assign found = (v_rd == val_q);

	always_comb begin
		ram_we = 1'b0;
		ram_addr = base + ADDR_BITS'(k_q[ENT_BITS-1:0]);
		v_wd = val_q;
		lo_wd = lowc_q;
		hi_wd = highc_q;
		unique case (state_q)
			ST_APPEND: begin
				ram_we = 1'b1;
				ram_addr = base + ADDR_BITS'(fill_c);
				lo_wd = (label_q == LABEL_LOW) ? COUNT_BITS'(1) : '0;
				hi_wd = (label_q == LABEL_HIGH) ? COUNT_BITS'(1) : '0;
			end
			ST_UPD: begin
				ram_addr = at_q;
				ram_we = !func_q;
				lo_wd = (label_q == LABEL_LOW && lowc_q != COUNT_MAX) ? lowc_q + 1'b1 : lowc_q;
				hi_wd = (label_q == LABEL_HIGH && highc_q != COUNT_MAX)
					? highc_q + 1'b1 : highc_q;
			end
			default: ;
		endcase
	end

	cnb_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(v_wd), .rdata(v_rd));
	cnb_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_lo (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(lo_wd), .rdata(lo_rd));
	cnb_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_hi (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(hi_wd), .rdata(hi_rd));

	// log operand select
	logic [COUNT_BITS-1:0] lsrc;
	always_comb begin
		unique case (lsel_q)
			2'd0: lsrc = lowc_q;
			2'd1: lsrc = tot_q[0];
			2'd2: lsrc = highc_q;
			default: lsrc = tot_q[1];
		endcase
	end

	// leading-one position by priority search
	logic [4:0] lead;
	always_comb begin
		lead = '0;
		for (int i = 0; i < COUNT_BITS; i++) begin
			if (lx_q[i]) begin
				lead = 5'(i);
			end
		end
	end

	logic [63:0] sq;
	logic [33:0] sqs;
	assign sq = {32'd0, lm_q} * {32'd0, lm_q};
	assign sqs = sq[63:30];

	// accumulate terms
	logic signed [SUM_BITS+1:0] nsum [2];
	logic [1:0] zero_c;
	always_comb begin
		zero_c[0] = (lowc_q == '0) || (tot_q[0] == '0);
		zero_c[1] = (highc_q == '0) || (tot_q[1] == '0);
		for (int c = 0; c < 2; c++) begin
			nsum[c] = (SUM_BITS+2)'(sum_q[c])
				+ $signed({2'b00, (SUM_BITS)'(lres_q[2*c])})
				- $signed({2'b00, (SUM_BITS)'(lres_q[2*c+1])});
		end
	end

	function automatic logic signed [SUM_BITS-1:0] sat(input logic signed [SUM_BITS+1:0] s);
		logic signed [SUM_BITS+1:0] mx, mn;
		mx = (SUM_BITS+2)'({1'b0, {(SUM_BITS-1){1'b1}}});
		mn = -mx - 1;
		if (s > mx) return mx[SUM_BITS-1:0];
		else if (s < mn) return mn[SUM_BITS-1:0];
		else return s[SUM_BITS-1:0];
	endfunction

	// prediction
	logic [1:0] pred;
	always_comb begin
		priority if (zflag_q == 2'b01) pred = LABEL_HIGH;
		else if (zflag_q != 2'b00) pred = LABEL_LOW;
		else pred = (sum_q[0] < sum_q[1]) ? LABEL_HIGH : LABEL_LOW;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = in_range ? ST_RD : ST_ROW;
			ST_RD: begin
				if (k_q >= fill_c) begin
					if (func_q != FUNC_TRAIN || fill_c == FULL) state_d = ST_ROW;
					else state_d = ST_APPEND;
				end else state_d = ST_CMP;
			end
			ST_CMP: state_d = found ? ST_UPD : ST_RD;
			ST_APPEND: state_d = ST_ROW;
			ST_UPD: state_d = (func_q == FUNC_TRAIN) ? ST_ROW : ST_LOGNORM;
			ST_LOGNORM: state_d = ST_LOGSQ;
			ST_LOGSQ: if (li_q == 4'd10) state_d = (lsel_q == 2'd3) ? ST_ACC : ST_LOGNORM;
			ST_ACC: state_d = ST_ROW;
			ST_ROW: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_FEATURES; i++) fill_q[i] <= '0;
			tot_q[0] <= '0;
			tot_q[1] <= '0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			zflag_q <= '0;
			ovf_q <= 1'b0;
			correct_q <= '0;
			k_q <= '0;
			lsel_q <= '0;
			li_q <= '0;
			at_q <= '0;
			lowc_q <= '0;
			highc_q <= '0;
			for (int i = 0; i < 4; i++) lres_q[i] <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: k_q <= '0;
				ST_CMP: begin
					k_q <= k_q + 1'b1;
					at_q <= ram_addr;
					lowc_q <= lo_rd;
					highc_q <= hi_rd;
				end
				ST_RD: if (k_q >= fill_c && func_q == FUNC_TRAIN && fill_c == FULL) ovf_q <= 1'b1;
				ST_APPEND: fill_q[col_q] <= fill_c + 1'b1;
				ST_UPD: begin
					lsel_q <= '0;
				end
				ST_LOGNORM: li_q <= '0;
				ST_LOGSQ: begin
					li_q <= li_q + 1'b1;
					if (li_q == 4'd10) begin
						lres_q[lsel_q] <= LOG_BITS'({le_q, lf_q, sqs[31]});
						lsel_q <= lsel_q + 1'b1;
					end
				end
				ST_ACC: begin
					for (int c = 0; c < 2; c++) begin
						if (zero_c[c]) zflag_q[c] <= 1'b1;
						else sum_q[c] <= sat(nsum[c]);
					end
				end
				ST_ROW: begin
					if (last_q) begin
						if (func_q == FUNC_TRAIN) begin
							if (label_q == LABEL_LOW && tot_q[0] != COUNT_MAX)
								tot_q[0] <= tot_q[0] + 1'b1;
							else if (label_q == LABEL_HIGH && tot_q[1] != COUNT_MAX)
								tot_q[1] <= tot_q[1] + 1'b1;
						end else begin
							done <= 1'b1;
							if (pred == label_q && correct_q != '1) correct_q <= correct_q + 1'b1;
							sum_q[0] <= '0;
							sum_q[1] <= '0;
							zflag_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload and log datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q <= func;
			col_q <= COL_BITS'(feature_index);
			val_q <= feature_value;
			label_q <= class_label;
			last_q <= last_of_row;
		end
		if (state_q == ST_LOGNORM) begin
			lx_q <= lsrc;
		end
		if (state_q == ST_ROW && last_q && func_q != FUNC_TRAIN) begin
			predicted_class <= pred;
			label_matches <= (pred == label_q);
			table_overflow <= ovf_q;
		end
		if (state_q == ST_LOGSQ) begin
			if (li_q == 4'd0) begin
				le_q <= lead;
				lm_q <= 32'({lx_q, 30'd0} >> lead);
				lf_q <= '0;
			end else begin
				lf_q <= {lf_q[7:0], sqs[31]};
				lm_q <= sqs[31] ? sqs[32:1] : sqs[31:0];
			end
		end
	end

	assign correct_total = correct_q;

`ifndef SYNTHESIS
	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_ROW)) else $error("done outside row end");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND) |-> (fill_c < FULL)) else $error("column fill beyond depth");
`endif
endmodule

/* bench/tb_top.sv */
// Testbench for the categorical naive Bayes classifier: directed rows, a column overflow fill, then random rows.
`timescale 1ns / 1ps
module tb_top;
	import cnb_pkg::*;

	localparam logic [0:0] FUNC_CLASSIFY = 1'b1;
	localparam logic [1:0] LABEL_NONE    = 2'd0;
	localparam logic [1:0] LABEL_UNKNOWN = 2'd3;
	localparam int NCOL  = NUM_FEATURES_D;
	localparam int DEPTH = ENTRIES_PER_COLUMN_D;
	localparam int CNT_MAX = (1 << COUNT_BITS_D) - 1;
	localparam int SUM_HI = (1 << (SUM_BITS - 1)) - 1;
	localparam int SUM_LO = -(1 << (SUM_BITS - 1));
	localparam int RANDOM_ITEMS = 1000;

	typedef struct packed {
		logic [1:0]              cls;
		logic                    hit;
		logic [CORRECT_BITS-1:0] n_correct;
		logic                    ovf;
	} verdict_t;

	typedef struct {
		logic [0:0]            fn;
		logic [3:0]            col;
		logic [VALUE_BITS-1:0] val;
		logic [1:0]            lab;
		logic                  last;
		bit                    typed;
		verdict_t              want;
	} row_t;

	logic clk, arst_n, start, busy, func, last_of_row, done;
	logic [3:0] feature_index;
	logic [VALUE_BITS-1:0] feature_value;
	logic [1:0] class_label, predicted_class;
	logic label_matches, table_overflow;
	logic [CORRECT_BITS-1:0] correct_total;

	categorical_naive_bayes_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.feature_index(feature_index), .feature_value(feature_value),
		.class_label(class_label), .last_of_row(last_of_row), .done(done),
		.predicted_class(predicted_class), .label_matches(label_matches),
		.correct_total(correct_total), .table_overflow(table_overflow)
	);

	// classifier state mirror
	logic [VALUE_BITS-1:0] seen_vals [NCOL][DEPTH];
	int unsigned low_cnt [NCOL][DEPTH];
	int unsigned high_cnt [NCOL][DEPTH];
	int unsigned col_fill [NCOL];
	int unsigned class_tot [2];
	int row_sum [2];
	logic [1:0] row_zero;
	logic ovf_seen;
	int unsigned n_right;

	verdict_t pending_verdicts[$];
	int mismatches, items_sent, verdicts_seen;
	int sender_idle_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

	function automatic int log2_q10(int unsigned x);
		int unsigned e;
		longint unsigned m;
		int unsigned fr;
		e = 0;
		fr = 0;
		while (e < 31 && (x >> (e + 1)) != 0)
			e++;
		m = longint'(x) << (30 - e);
		for (int i = 0; i < 10; i++) begin
			m = (m * m) >> 30;
			fr = fr << 1;
			if (m >= (64'd1 << 31)) begin
				fr |= 1;
				m >>= 1;
			end
		end
		return int'(e * 1024 + fr);
	endfunction

	function automatic void add_log_term(int c, int unsigned cnt, int unsigned tot);
		longint s;
		if (cnt == 0 || tot == 0) begin
			row_zero[c] = 1'b1;
			return;
		end
		s = longint'(row_sum[c]) + log2_q10(cnt) - log2_q10(tot);
		if (s > SUM_HI) s = SUM_HI;
		if (s < SUM_LO) s = SUM_LO;
		row_sum[c] = int'(s);
	endfunction

	function automatic int unsigned sat_inc(int unsigned v);
		return (v < CNT_MAX) ? v + 1 : v;
	endfunction

	// applies one item to the mirror; returns 1 when a verdict is due
	function automatic bit classify_item(logic [0:0] fn, logic [3:0] col,
			logic [VALUE_BITS-1:0] val, logic [1:0] lab, logic last, output verdict_t v);
		int unsigned fill, at;
		bit found;
		logic [1:0] cls;
		v = '0;
		if (col < NCOL) begin
			fill = col_fill[col];
			found = 0;
			at = 0;
			for (int k = 0; k < fill; k++)
				if (!found && seen_vals[col][k] == val) begin
					found = 1;
					at = k;
				end
			if (fn == FUNC_TRAIN) begin
				if (!found) begin
					if (fill < DEPTH) begin
						at = fill;
						seen_vals[col][at] = val;
						low_cnt[col][at] = 0;
						high_cnt[col][at] = 0;
						col_fill[col] = fill + 1;
						found = 1;
					end else
						ovf_seen = 1'b1;
				end
				if (found) begin
					if (lab == LABEL_LOW) low_cnt[col][at] = sat_inc(low_cnt[col][at]);
					else if (lab == LABEL_HIGH) high_cnt[col][at] = sat_inc(high_cnt[col][at]);
				end
			end else if (found) begin
				add_log_term(0, low_cnt[col][at], class_tot[0]);
				add_log_term(1, high_cnt[col][at], class_tot[1]);
			end
		end
		if (!last) return 0;
		if (fn == FUNC_TRAIN) begin
			if (lab == LABEL_LOW) class_tot[0] = sat_inc(class_tot[0]);
			else if (lab == LABEL_HIGH) class_tot[1] = sat_inc(class_tot[1]);
			return 0;
		end
		if (row_zero == 2'b01) cls = LABEL_HIGH;
		else if (row_zero != 2'b00) cls = LABEL_LOW;
		else cls = (row_sum[0] < row_sum[1]) ? LABEL_HIGH : LABEL_LOW;
		v.cls = cls;
		v.hit = (cls == lab);
		if (v.hit && n_right < 65535) n_right++;
		v.n_correct = n_right[15:0];
		v.ovf = ovf_seen;
		row_sum[0] = 0;
		row_sum[1] = 0;
		row_zero = 2'b00;
		return 1;
	endfunction

	task automatic send_item(row_t r);
		verdict_t v;
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start <= 1'b1;
		func <= r.fn;
		feature_index <= r.col;
		feature_value <= r.val;
		class_label <= r.lab;
		last_of_row <= r.last;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		items_sent++;
		if (classify_item(r.fn, r.col, r.val, r.lab, r.last, v))
			pending_verdicts.insert(pending_verdicts.size(), r.typed ? r.want : v);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		verdict_t got, exp_v;
		if (arst_n && done) begin
			got = '{predicted_class, label_matches, correct_total, table_overflow};
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected verdict %p", got);
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (got !== exp_v) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_v, got);
				end
			end
		end
	end

	function automatic row_t mk(logic [0:0] fn, logic [3:0] col, logic [VALUE_BITS-1:0] val,
			logic [1:0] lab, logic last);
		row_t r;
		r.fn = fn; r.col = col; r.val = val; r.lab = lab; r.last = last;
		r.typed = 0;
		r.want = '0;
		return r;
	endfunction

	initial begin
		row_t plan[$];
		row_t r;
		int nfeat;
		bit trn;
		logic [1:0] lab;
		arst_n = 1'b0;
		start = 1'b0; func = 1'b0; feature_index = '0; feature_value = '0;
		class_label = '0; last_of_row = 1'b0;
		foreach (col_fill[i]) col_fill[i] = 0;
		class_tot = '{0, 0}; row_sum = '{0, 0};
		row_zero = '0; ovf_seen = 0; n_right = 0;
		mismatches = 0; items_sent = 0; verdicts_seen = 0;
		sender_idle_pct = 15;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows
		r = mk(FUNC_CLASSIFY, 4'd0, '0, LABEL_LOW, 1'b1);
		r.typed = 1; r.want = '{LABEL_LOW, 1'b1, 16'd1, 1'b0};
		plan.insert(plan.size(), r);
		r = mk(FUNC_CLASSIFY, 4'd15, '1, LABEL_HIGH, 1'b1);
		r.typed = 1; r.want = '{LABEL_LOW, 1'b0, 16'd1, 1'b0};
		plan.insert(plan.size(), r);
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd0, 21'd5, LABEL_LOW, 1'b0));
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd1, '1, LABEL_LOW, 1'b1));
		plan.insert(plan.size(), mk(FUNC_CLASSIFY, 4'd0, 21'd5, LABEL_LOW, 1'b0));
		plan.insert(plan.size(), mk(FUNC_CLASSIFY, 4'd1, '1, LABEL_HIGH, 1'b1));
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd0, 21'd5, LABEL_HIGH, 1'b1));
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd0, 21'd7, LABEL_UNKNOWN, 1'b1));
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd2, 21'd1, LABEL_NONE, 1'b1));
		plan.insert(plan.size(), mk(FUNC_CLASSIFY, 4'd0, 21'd7, LABEL_HIGH, 1'b1));
		plan.insert(plan.size(), mk(FUNC_CLASSIFY, 4'd0, 21'd5, LABEL_LOW, 1'b1));
		plan.insert(plan.size(), mk(FUNC_CLASSIFY, 4'd4, 21'd99, LABEL_HIGH, 1'b1));
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd15, 21'd3, LABEL_LOW, 1'b1));
		plan.insert(plan.size(), mk(FUNC_TRAIN, 4'd14, 21'h155555, LABEL_HIGH, 1'b1));
		plan.insert(plan.size(), mk(FUNC_CLASSIFY, 4'd13, 21'h0AAAAA, LABEL_UNKNOWN, 1'b1));
		foreach (plan[i]) send_item(plan[i]);

		// fill column 13 past its capacity
		for (int k = 0; k <= DEPTH; k++)
			send_item(mk(FUNC_TRAIN, 4'd13, 21'(k * 8191), 2'($urandom_range(0, 3)),
				1'b0));
		send_item(mk(FUNC_TRAIN, 4'd13, 21'd0, LABEL_HIGH, 1'b1));
		send_item(mk(FUNC_CLASSIFY, 4'd13, 21'd8191, LABEL_LOW, 1'b1));

		while (items_sent < RANDOM_ITEMS + 290) begin
			if (items_sent > 290 + RANDOM_ITEMS / 3) sender_idle_pct = 71;
			if (items_sent > 290 + 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
			trn = (items_sent < 420) || ($urandom_range(0, 99) < 45);
			lab = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3))
				: 2'($urandom_range(1, 2));
			nfeat = $urandom_range(1, 6);
			for (int f = 0; f < nfeat; f++) begin
				r = mk(trn ? FUNC_TRAIN : FUNC_CLASSIFY, 4'($urandom_range(0, 12)),
					21'($urandom_range(0, 7)), lab, f == nfeat - 1);
				if ($urandom_range(0, 29) == 0) r.col = 4'($urandom_range(13, 15));
				if ($urandom_range(0, 9) == 0) r.val = 21'($urandom);
				send_item(r);
			end
		end
		start <= 1'b0;

		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("%0d items sent, %0d verdicts checked, %0d mismatches",
			items_sent, verdicts_seen, mismatches);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* categorical_naive_bayes_top.f */
rtl/cnb_pkg.sv
rtl/cnb_ram.sv
rtl/categorical_naive_bayes_top.sv
bench/tb_top.sv
